// File: src/scp_pkg.sv
package scp_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int IN_W          = 16;
    localparam int SLOT_W        = 4;
    localparam int EVICT_W       = 16;
    localparam int COUNT_W       = 32;
    localparam int OUT_W         = 88;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic set_ref;
        logic clr_ref;
        logic load;
    } scp_cmd_t;

    typedef struct packed {
        logic valid;
        logic refd;
    } scp_status_t;

endpackage

// File: src/scp_cell.sv
module scp_cell #(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF,
    parameter int CNT_W     = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      n,
    input  logic [PAGE_BITS-1:0]  key,
    input  logic                  sel,
    input  scp_pkg::scp_cmd_t     cmd,
    input  logic                  match_in,
    output logic                  match_out,
    output logic                  first,
    output scp_pkg::scp_status_t  status,
    output logic [PAGE_BITS-1:0]  page
);
    import scp_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 ref_reg, ref_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 here;

    assign here      = valid_reg && (CNT_W'(IDX) < n) && (page_reg == key);
    assign first     = here && !match_in;
    assign match_out = match_in || here;
    assign status    = '{valid: valid_reg, refd: ref_reg};
    assign page      = page_reg;

    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        if (cmd.load && sel)
        begin
            valid_next = 1'b1;
            ref_next   = 1'b0;
        end
        else if (cmd.clr_ref && sel)
        begin
            ref_next = 1'b0;
        end
        else if (cmd.set_ref && first)
        begin
            ref_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ref_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && sel)
        begin
            page_reg <= key;
        end
    end

endmodule

// File: src/second_chance_page_replacement.sv
// Second-chance (clock) page replacement over a row of table cells, one cell per entry.
// A request passes accept, lookup through the cell match chain and result on a hit; a fault
// adds a sweep that clears the reference bit of each referenced entry the hand passes, one
// cell examined per cycle, and loads the first other entry. A new request is accepted once
// the previous result has moved to the output register. entries_in_use is sampled with each
// request; 0 acts as 1 and values above ENTRIES act as ENTRIES. Counters saturate.
module second_chance_page_replacement #(
    parameter int ENTRIES   = scp_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [scp_pkg::CFG_W-1:0]   cfg_wdata,   // entries_in_use
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [scp_pkg::IN_W-1:0]    s_tdata,     // page_number
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, slot[3:0], evicted_valid, evicted_page[15:0], fault_total[31:0],
    // request_total[31:0], zero pad
    output logic [scp_pkg::OUT_W-1:0]   m_tdata
);
    import scp_pkg::*;

    localparam int HAND_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [PAGE_BITS-1:0] key_reg, key_next;
    logic [HAND_W-1:0]    hand_reg, hand_next;
    logic [COUNT_W-1:0]   fault_reg, fault_next;
    logic [COUNT_W-1:0]   req_reg, req_next;
    logic                 res_hit_reg, res_hit_next;
    logic [HAND_W-1:0]    res_slot_reg, res_slot_next;
    logic                 res_ev_reg, res_ev_next;
    logic [PAGE_BITS-1:0] res_page_reg, res_page_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [ENTRIES:0]     match;
    logic [ENTRIES-1:0]   first;
    logic [ENTRIES-1:0]   sel;
    scp_status_t          status [ENTRIES];
    logic [PAGE_BITS-1:0] cell_page [ENTRIES];
    scp_cmd_t             cmd;
    logic [HAND_W-1:0]    hit_idx;
    logic [HAND_W-1:0]    hand_inc;
    logic                 accept;

    assign match[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign sel[i] = (hand_reg == HAND_W'(i));
        scp_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .n         (n_reg),
            .key       (key_reg),
            .sel       (sel[i]),
            .cmd       (cmd),
            .match_in  (match[i]),
            .match_out (match[i+1]),
            .first     (first[i]),
            .status    (status[i]),
            .page      (cell_page[i])
        );
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first[i])
            begin
                hit_idx = hit_idx | HAND_W'(i);
            end
        end
    end

    assign hand_inc = ((CNT_W'(hand_reg) + 1'b1) == n_reg) ? '0 : HAND_W'(hand_reg + 1'b1);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        key_next      = key_reg;
        hand_next     = hand_reg;
        fault_next    = fault_reg;
        req_next      = req_reg;
        res_hit_next  = res_hit_reg;
        res_slot_next = res_slot_reg;
        res_ev_next   = res_ev_reg;
        res_page_next = res_page_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cmd           = '{set_ref: 1'b0, clr_ref: 1'b0, load: 1'b0};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = PAGE_BITS'(s_tdata);
                    if (cfg_reg == '0)
                    begin
                        n_next = CNT_W'(1);
                    end
                    else if (32'(cfg_reg) > 32'(ENTRIES))
                    begin
                        n_next = CNT_W'(ENTRIES);
                    end
                    else
                    begin
                        n_next = CNT_W'(cfg_reg);
                    end
                    if (req_reg != COUNT_MAX)
                    begin
                        req_next = req_reg + 1'b1;
                    end
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (match[ENTRIES])
                begin
                    cmd.set_ref   = 1'b1;
                    res_hit_next  = 1'b1;
                    res_slot_next = hit_idx;
                    res_ev_next   = 1'b0;
                    res_page_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    if (fault_reg != COUNT_MAX)
                    begin
                        fault_next = fault_reg + 1'b1;
                    end
                    if (CNT_W'(hand_reg) >= n_reg)
                    begin
                        hand_next = '0;
                    end
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                hand_next = hand_inc;
                if (status[hand_reg].valid && status[hand_reg].refd)
                begin
                    cmd.clr_ref = 1'b1;
                end
                else
                begin
                    cmd.load      = 1'b1;
                    res_hit_next  = 1'b0;
                    res_slot_next = hand_reg;
                    res_ev_next   = status[hand_reg].valid;
                    res_page_next = status[hand_reg].valid ? cell_page[hand_reg] : '0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, req_reg, fault_reg, EVICT_W'(res_page_reg),
                                     res_ev_reg, SLOT_W'(res_slot_reg), res_hit_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cfg_reg      <= CFG_RESET;
            hand_reg     <= '0;
            fault_reg    <= '0;
            req_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hand_reg     <= hand_next;
            fault_reg    <= fault_next;
            req_reg      <= req_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        key_reg      <= key_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        res_ev_reg   <= res_ev_next;
        res_page_reg <= res_page_next;
        m_tdata_reg  <= m_tdata_next;
    end

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (CNT_W'(hand_reg) < n_reg))
        else $error("hand outside active entries during sweep");

    a_faults_le_requests: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg <= req_reg)
        else $error("fault count exceeds request count");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first))
        else $error("more than one cell claims the hit");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented outside completion");

endmodule
